@@ rtl/rdsp_pkg.sv @@
// Package for the ramped dual stereo panner: constants, types, tables and index math.
package rdsp_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int SINE_DEPTH  = 1024;
  localparam int GAIN_DEPTH  = 1024;
  localparam int MAX_BLOCK   = 4096;
  localparam int SIW         = $clog2(SINE_DEPTH);
  localparam int GIW         = $clog2(GAIN_DEPTH);
  localparam int SET_W       = 16;
  localparam int LEN_W       = 13;
  localparam int COEF_W      = 24;

  localparam logic [2:0] REG_LEFT_GAIN   = 3'd0;
  localparam logic [2:0] REG_LEFT_PAN    = 3'd1;
  localparam logic [2:0] REG_RIGHT_GAIN  = 3'd2;
  localparam logic [2:0] REG_RIGHT_PAN   = 3'd3;
  localparam logic [2:0] REG_BLOCK_FRAMES = 3'd4;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned GOLDEN_Q30  = 64'd663608942;
  localparam longint unsigned LN2_Q30     = 64'd744261118;

  typedef logic [COEF_W-1:0] sine_tab_t [SINE_DEPTH];
  typedef logic [COEF_W-1:0] gain_tab_t [GAIN_DEPTH];

  typedef struct packed {
    logic             start;
    logic [SET_W-1:0] num;
    logic [LEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SET_W-1:0] quo;
    logic [LEN_W-1:0] rem;
  } div_rsp_t;

  // Shift-and-subtract quotient, used only while the tables are built.
  function automatic longint unsigned udiv(input longint unsigned a,
                                           input longint unsigned b);
    longint unsigned q, r;
    begin
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        r = (r << 1) | ((a >> i) & 64'd1);
        q = q << 1;
        if (r >= b) begin
          r = r - b;
          q = q | 64'd1;
        end
      end
      udiv = q;
    end
  endfunction

  function automatic logic [COEF_W-1:0] sine_entry(input longint unsigned k);
    longint unsigned d, th, t2, term;
    longint sum;
    begin
      d = longint'(SINE_DEPTH) - 1;
      th = udiv(HALF_PI_Q30 * k + (d >> 1), d);
      t2 = (th * th) >> 30;
      term = th;
      sum = longint'(th);
      for (int n = 1; n <= 12; n++) begin
        term = udiv((term * t2) >> 30, longint'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
      sine_entry = COEF_W'((longint'(sum) + 128) >>> 8);
    end
  endfunction

  function automatic longint unsigned exp2_frac(input longint unsigned f);
    longint unsigned u, sum, term;
    begin
      u = (f * LN2_Q30) >> 30;
      sum = Q30_ONE;
      term = Q30_ONE;
      for (int i = 1; i <= 24; i++) begin
        if (term != 0) begin
          term = udiv((term * u) >> 30, longint'(i));
          sum = sum + term;
        end
      end
      exp2_frac = sum;
    end
  endfunction

  function automatic logic [COEF_W-1:0] gain_entry(input longint unsigned k);
    longint unsigned d, x, m, frac, mag, p, f, v;
    longint e, lg, n;
    int s;
    begin
      d = longint'(GAIN_DEPTH) - 1;
      x = udiv(2 * k * Q30_ONE + (d >> 1), d);
      m = x;
      frac = 0;
      e = 0;
      gain_entry = '0;
      if (x != 0) begin
        while (m < Q30_ONE) begin
          m = m << 1;
          e = e - 1;
        end
        while (m >= 2 * Q30_ONE) begin
          m = m >> 1;
          e = e + 1;
        end
        for (int i = 0; i < 30; i++) begin
          m = (m * m) >> 30;
          frac = frac << 1;
          if (m >= 2 * Q30_ONE) begin
            m = m >> 1;
            frac = frac | 1;
          end
        end
        lg = e * longint'(Q30_ONE) + longint'(frac);
        mag = (lg < 0) ? longint'(-lg) : longint'(lg);
        p = (mag * ((x + GOLDEN_Q30) >> 2)) >> 28;
        if (lg >= 0) begin
          n = longint'(p >> 30);
          f = p & (Q30_ONE - 1);
        end else if ((p & (Q30_ONE - 1)) == 0) begin
          n = -longint'(p >> 30);
          f = 0;
        end else begin
          n = -longint'(p >> 30) - 1;
          f = Q30_ONE - (p & (Q30_ONE - 1));
        end
        v = exp2_frac(f);
        if (10 - n < 62) begin
          s = int'(10 - n);
          gain_entry = COEF_W'((v + (64'd1 << (s - 1))) >> s);
        end
      end
    end
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    begin
      for (int k = 0; k < SINE_DEPTH; k++) t[k] = sine_entry(longint'(k));
      build_sine = t;
    end
  endfunction

  function automatic gain_tab_t build_gain();
    gain_tab_t t;
    begin
      for (int k = 0; k < GAIN_DEPTH; k++) t[k] = gain_entry(longint'(k));
      build_gain = t;
    end
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam gain_tab_t GAIN_TAB = build_gain();

  // round(v*Dm/65535): 65535 is 2^16-1, so the reciprocal is a shifted add with
  // one correction step.
  function automatic logic [12:0] pick(input logic [SET_W-1:0] v, input int Dm);
    logic [29:0] n, q0, back;
    begin
      n = 30'(v) * 30'(Dm) + 30'd32767;
      q0 = (n + (n >> 16)) >> 16;
      back = (q0 << 16) - q0;
      if (n - back >= 30'd65535) q0 = q0 + 30'd1;
      if (q0 > 30'(Dm)) q0 = 30'(Dm);
      pick = q0[12:0];
    end
  endfunction

endpackage

@@ rtl/rdsp_if.sv @@
// Valid/ready channel interfaces for sample input and mixed output words.
interface rdsp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rdsp_pkg::SAMPLE_BITS-1:0] sample_left;
  logic signed [rdsp_pkg::SAMPLE_BITS-1:0] sample_right;
  logic                                 block_start;
  modport source(output valid, sample_left, sample_right, block_start, input ready);
  modport sink(input valid, sample_left, sample_right, block_start, output ready);
endinterface

interface rdsp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rdsp_pkg::SAMPLE_BITS-1:0] out_left;
  logic signed [rdsp_pkg::SAMPLE_BITS-1:0] out_right;
  logic                                 clipped;
  modport source(output valid, out_left, out_right, clipped, input ready);
  modport sink(input valid, out_left, out_right, clipped, output ready);
endinterface

@@ rtl/rdsp_div.sv @@
// Restoring divider, one quotient bit per cycle, for the ramp step size.
module rdsp_div (
  input  logic                clk,
  input  logic                rst,
  input  rdsp_pkg::div_req_t  req,
  output rdsp_pkg::div_rsp_t  rsp
);
  import rdsp_pkg::*;

  logic [SET_W-1:0] num;
  logic [SET_W-1:0] quo;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] den;
  logic [4:0]       cnt;
  logic             busy;
  logic             done;
  logic [LEN_W:0]   trial;

  assign trial = {rem, num[SET_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
        quo  <= '0;
        cnt  <= 5'(SET_W);
      end else if (busy) begin
        num <= num << 1;
        if (trial >= {1'b0, den}) begin
          rem <= LEN_W'(trial - {1'b0, den});
          quo <= {quo[SET_W-2:0], 1'b1};
        end else begin
          rem <= trial[LEN_W-1:0];
          quo <= {quo[SET_W-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;
endmodule

@@ rtl/ramped_dual_stereo_panner_unit.sv @@
// Top level of the ramped dual stereo panner with one shared multiplier.
//
// Usage: each word on the samples channel carries a left and a right Q1.23
// sample and a block_start mark. Each input gets its own gain and sine-law
// pan, and both are mixed onto out_left and out_right of one word on the
// mixed channel, rounded and saturated; clipped flags saturation.
// Settings are written through cfg_we/cfg_index/cfg_data while the unit is
// idle; a block_start word latches the new targets and the block length, and
// the four settings then ramp linearly over that many words.
// Each word takes two passes of nine steps through the shared multiplier, then
// the store into the output register.
// A block_start word first runs the four ramp step divisions, done by
// the bit-serial divider one setting after another.
// One word is in work at a time, so a new word is taken only after the last
// one is stored; samples.ready is high only while the sequencer is idle, and
// a new word may enter while the previous result waits on the mixed channel.
// On a stall, the next result waits in the sequencer until the last is taken.
// Reset (rst, synchronous) restores all targets to mid scale, a block length
// of 512 and a finished ramp; no word is pending afterwards.
module ramped_dual_stereo_panner_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [rdsp_pkg::SET_W-1:0]   cfg_data,
  rdsp_in_if.sink                      samples,
  rdsp_out_if.source                   mixed
);
  import rdsp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DGO  = 4'd1;
  localparam logic [3:0] S_DWT  = 4'd2;
  localparam logic [3:0] S_PG   = 4'd3;
  localparam logic [3:0] S_PP   = 4'd4;
  localparam logic [3:0] S_TAB  = 4'd5;
  localparam logic [3:0] S_ML   = 4'd6;
  localparam logic [3:0] S_MR   = 4'd7;
  localparam logic [3:0] S_AL   = 4'd8;
  localparam logic [3:0] S_AR   = 4'd9;
  localparam logic [3:0] S_AC   = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam int ACC_W = 48;
  localparam int PRD_W = 50;

  logic [3:0]       state;
  logic [SET_W-1:0] tgt    [4];
  logic [LEN_W-1:0] frames;
  logic [SET_W-1:0] rstart [4];
  logic [SET_W-1:0] rend   [4];
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] remain;
  logic [SET_W-1:0] qv     [4];
  logic [LEN_W-1:0] rv     [4];
  logic signed [17:0] qd   [4];
  logic [LEN_W-1:0] rd     [4];
  logic [1:0]       lane;
  logic             dneg;
  logic             ch;
  logic signed [SAMPLE_BITS-1:0] smp_l, smp_r;
  logic [GIW-1:0]   gidx;
  logic [SIW-1:0]   pidx;
  logic [COEF_W-1:0] gval, sl, sr, cl, cr;
  logic signed [PRD_W-1:0] prod;
  logic signed [ACC_W-1:0] accl, accr;
  logic signed [24:0] ma, mb;
  logic signed [PRD_W-1:0] rnd;
  logic signed [16:0] diff;
  logic [LEN_W-1:0] frames_cl;
  logic signed [ACC_W-1:0] fl, fr;
  logic signed [ACC_W-21:0] sh_l, sh_r;
  logic             clip_l, clip_r;
  logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;
  logic signed [SAMPLE_BITS-1:0] smp_c;
  div_req_t         dreq;
  div_rsp_t         drsp;

  rdsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign diff      = $signed({1'b0, rend[lane]}) - $signed({1'b0, rstart[lane]});
  assign dreq.start = (state == S_DGO);
  assign dreq.num   = diff[16] ? SET_W'(-diff) : SET_W'(diff);
  assign dreq.den   = len;

  assign frames_cl = (frames == '0) ? LEN_W'(1) :
                     (frames > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : frames;

  assign samples.ready = (state == S_IDLE);
  assign smp_c = ch ? smp_r : smp_l;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      S_ML: begin
        ma = $signed({1'b0, sl});
        mb = $signed({1'b0, gval});
      end
      S_MR: begin
        ma = $signed({1'b0, sr});
        mb = $signed({1'b0, gval});
      end
      S_AL: begin
        ma = 25'(smp_c);
        mb = $signed({1'b0, cl});
      end
      S_AR: begin
        ma = 25'(smp_c);
        mb = $signed({1'b0, cr});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign rnd = prod + PRD_W'(2097152);

  // Round half up by the Q20 step, then saturate.
  assign fl   = accl + ACC_W'(524288);
  assign fr   = accr + ACC_W'(524288);
  assign sh_l = fl[ACC_W-1:20];
  assign sh_r = fr[ACC_W-1:20];
  always_comb begin
    clip_l = 1'b0;
    clip_r = 1'b0;
    sat_l  = sh_l[SAMPLE_BITS-1:0];
    sat_r  = sh_r[SAMPLE_BITS-1:0];
    if (sh_l > (ACC_W-20)'(2**(SAMPLE_BITS-1) - 1)) begin
      sat_l  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      clip_l = 1'b1;
    end else if (sh_l < -(ACC_W-20)'(2**(SAMPLE_BITS-1))) begin
      sat_l  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      clip_l = 1'b1;
    end
    if (sh_r > (ACC_W-20)'(2**(SAMPLE_BITS-1) - 1)) begin
      sat_r  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      clip_r = 1'b1;
    end else if (sh_r < -(ACC_W-20)'(2**(SAMPLE_BITS-1))) begin
      sat_r  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      clip_r = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    logic [LEN_W:0]   rsum;
    logic [17:0]      qn;
    logic signed [17:0] qfix;
    logic [LEN_W-1:0] rfix;
    if (rst) begin
      state  <= S_IDLE;
      frames <= LEN_W'(512);
      len    <= LEN_W'(512);
      remain <= '0;
      mixed.valid <= 1'b0;
      ch     <= 1'b0;
      lane   <= '0;
      for (int l = 0; l < 4; l++) begin
        tgt[l]    <= SET_W'(32768);
        rstart[l] <= SET_W'(32768);
        rend[l]   <= SET_W'(32768);
        qv[l]     <= SET_W'(32768);
        rv[l]     <= '0;
        qd[l]     <= '0;
        rd[l]     <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_GAIN:    tgt[0] <= cfg_data;
          REG_LEFT_PAN:     tgt[1] <= cfg_data;
          REG_RIGHT_GAIN:   tgt[2] <= cfg_data;
          REG_RIGHT_PAN:    tgt[3] <= cfg_data;
          REG_BLOCK_FRAMES: frames <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (state == S_OUT && (!mixed.valid || mixed.ready)) mixed.valid <= 1'b1;
      else if (mixed.valid && mixed.ready) mixed.valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            smp_l <= samples.sample_left;
            smp_r <= samples.sample_right;
            accl  <= '0;
            accr  <= '0;
            ch    <= 1'b0;
            if (samples.block_start) begin
              for (int l = 0; l < 4; l++) begin
                rstart[l] <= rend[l];
                rend[l]   <= tgt[l];
              end
              len    <= frames_cl;
              remain <= frames_cl - LEN_W'(1);
              lane   <= '0;
              state  <= S_DGO;
            end else begin
              // While the ramp runs, step every setting by one ramp increment, carrying the remainder.
              if (remain != '0) begin
                remain <= remain - LEN_W'(1);
                for (int l = 0; l < 4; l++) begin
                  rsum = {1'b0, rv[l]} + {1'b0, rd[l]};
                  qn   = 18'(qv[l]) + 18'(qd[l]);
                  if (rsum >= {1'b0, len}) begin
                    rv[l] <= LEN_W'(rsum - {1'b0, len});
                    qv[l] <= SET_W'(qn + 18'd1);
                  end else begin
                    rv[l] <= rsum[LEN_W-1:0];
                    qv[l] <= qn[SET_W-1:0];
                  end
                end
              end
              state <= S_PG;
            end
          end
        end
        S_DGO: begin
          dneg  <= diff[16];
          state <= S_DWT;
        end
        S_DWT: begin
          if (drsp.done) begin
            // Floor division with a nonnegative remainder.
            if (dneg && drsp.rem != '0) begin
              qfix = -$signed(18'(drsp.quo)) - 18'sd1;
              rfix = len - drsp.rem;
            end else if (dneg) begin
              qfix = -$signed(18'(drsp.quo));
              rfix = '0;
            end else begin
              qfix = $signed(18'(drsp.quo));
              rfix = drsp.rem;
            end
            qd[lane] <= qfix;
            rd[lane] <= rfix;
            qn = 18'(rstart[lane]) + 18'(qfix);
            qv[lane] <= qn[SET_W-1:0];
            rv[lane] <= rfix;
            lane <= lane + 2'd1;
            state <= (lane == 2'd3) ? S_PG : S_DGO;
          end
        end
        S_PG: begin
          gidx  <= GIW'(pick(ch ? qv[2] : qv[0], GAIN_DEPTH - 1));
          state <= S_PP;
        end
        S_PP: begin
          pidx  <= SIW'(pick(ch ? qv[3] : qv[1], SINE_DEPTH - 1));
          gval  <= GAIN_TAB[gidx];
          state <= S_TAB;
        end
        S_TAB: begin
          sl    <= SINE_TAB[SIW'(SINE_DEPTH - 1) - pidx];
          sr    <= SINE_TAB[pidx];
          state <= S_ML;
        end
        S_ML: begin
          prod  <= ma * mb;
          state <= S_MR;
        end
        S_MR: begin
          cl    <= rnd[COEF_W+21:22];
          prod  <= ma * mb;
          state <= S_AL;
        end
        S_AL: begin
          cr    <= rnd[COEF_W+21:22];
          prod  <= ma * mb;
          state <= S_AR;
        end
        S_AR: begin
          accl  <= accl + prod[ACC_W-1:0];
          prod  <= ma * mb;
          state <= S_AC;
        end
        S_AC: begin
          accr  <= accr + prod[ACC_W-1:0];
          state <= S_FIN;
        end
        S_FIN: begin
          if (ch == 1'b0) begin
            ch    <= 1'b1;
            state <= S_PG;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!mixed.valid || mixed.ready) begin
            mixed.out_left  <= sat_l;
            mixed.out_right <= sat_r;
            mixed.clipped   <= clip_l | clip_r;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_remain_below_len: assert property (@(posedge clk) disable iff (rst)
    remain < len) else $error("ramp count reached the block length");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("second word taken while one is in work");
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == S_DWT) else $error("divider finished outside its wait");
  a_frac_below_len: assert property (@(posedge clk) disable iff (rst)
    state == S_PG |-> rv[0] < len) else $error("ramp remainder not reduced");
`endif
endmodule
